@@ hw/rtl/pgru_pkg.sv @@
// Shared types, constants and helper functions for the pixel gain reference update block.
// No dependencies; every other file of the block imports this package.
package pgru_pkg;

	localparam int IDX_W = 14;
	localparam int VAL_W = 32;
	localparam int CNT_W = 24;
	localparam int SUM_W = 48;
	localparam int QUO_W = 48;
	localparam int NUM_W = 51;
	localparam int CFG_W = 16;

	localparam logic [1:0] REG_MODE        = 2'd0;
	localparam logic [1:0] REG_IMAGE_COUNT = 2'd1;
	localparam logic [1:0] REG_TOLERANCE   = 2'd2;

	localparam logic signed [VAL_W-1:0] GAIN_MAX = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic [IDX_W-1:0]        pixel_index;
		logic signed [VAL_W-1:0] pixel_value;
		logic                    pass_start;
	} pgru_in_t;

	typedef struct packed {
		logic [IDX_W-1:0]        out_index;
		logic signed [VAL_W-1:0] new_gain;
		logic [3:0]              code;
		logic [CNT_W-1:0]        overflows;
		logic [CNT_W-1:0]        bad_pixels;
		logic [CNT_W-1:0]        unresolved;
		logic [SUM_W-1:0]        deviation_total;
	} pgru_out_t;

	// Item as classified by the front end
	typedef struct packed {
		logic [IDX_W-1:0]        idx;
		logic signed [VAL_W-1:0] value;
		logic                    pass_start;
		logic                    is_est;
		logic                    v_zero;
		logic                    v_nonpos;
	} pgru_item_t;

	function automatic logic [VAL_W-1:0] mag32(input logic signed [VAL_W-1:0] x);
		return x[VAL_W-1] ? VAL_W'(-x) : VAL_W'(x);
	endfunction

	function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] c);
		return (&c) ? c : c + CNT_W'(1);
	endfunction

	function automatic logic [SUM_W-1:0] add_sat(input logic [SUM_W-1:0] a,
			input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

endpackage

@@ hw/rtl/pgru_div.sv @@
// Iterative unsigned divider, two quotient bits per cycle, 48-bit quotient.
// Depends on pgru_pkg. A short run takes a 16-bit dividend.
module pgru_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      short_run,
	input  logic [pgru_pkg::NUM_W-1:0] num,
	input  logic [31:0]               den,
	output logic                      done,
	output logic [pgru_pkg::QUO_W-1:0] quo
);
	import pgru_pkg::*;

	logic [31:0]      rem_q;
	logic [31:0]      den_q;
	logic [QUO_W-1:0] src_q;
	logic [QUO_W-1:0] quo_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [32:0] t1, t2;
	logic [31:0] r1, r2;
	logic        b1, b2;

	always_comb begin
		t1 = {rem_q, src_q[QUO_W-1]};
		b1 = t1 >= {1'b0, den_q};
		r1 = b1 ? 32'(t1 - {1'b0, den_q}) : t1[31:0];
		t2 = {r1, src_q[QUO_W-2]};
		b2 = t2 >= {1'b0, den_q};
		r2 = b2 ? 32'(t2 - {1'b0, den_q}) : t2[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= short_run ? 5'd8 : 5'd24;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			quo_q <= '0;
			if (short_run) begin
				rem_q <= '0;
				src_q <= {num[15:0], 32'd0};
			end else begin
				rem_q <= {29'd0, num[NUM_W-1:QUO_W]};
				src_q <= num[QUO_W-1:0];
			end
		end else if (busy_q) begin
			rem_q <= r2;
			src_q <= {src_q[QUO_W-3:0], 2'b00};
			quo_q <= {quo_q[QUO_W-3:0], b1, b2};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

@@ hw/rtl/pgru_front.sv @@
// Front end: accepts pixels, classifies them and holds them in a two-entry queue.
// Depends on pgru_pkg.
module pgru_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  hold,
	input  logic                  mode,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pgru_pkg::pgru_in_t    in_data,
	output logic                  item_valid,
	input  logic                  item_ready,
	output pgru_pkg::pgru_item_t  item
);
	import pgru_pkg::*;

	pgru_item_t q_mem [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;
	logic       push, pop;
	pgru_item_t cls;

	always_comb begin
		cls.idx        = in_data.pixel_index;
		cls.value      = in_data.pixel_value;
		cls.pass_start = in_data.pass_start;
		cls.is_est     = !mode;
		cls.v_zero     = in_data.pixel_value == '0;
		cls.v_nonpos   = in_data.pixel_value[VAL_W-1] || in_data.pixel_value == '0;
	end

	assign in_ready   = (fill_q != 2'd2) && !hold;
	assign push       = in_valid && in_ready;
	assign item_valid = fill_q != 2'd0;
	assign pop        = item_valid && item_ready;
	assign item       = q_mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem[wr_ptr_q] <= cls;
	end
endmodule

@@ hw/rtl/pgru_back.sv @@
// Back end: gain table, update sequencer, statistics and result register.
// Depends on pgru_pkg and pgru_div.
module pgru_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  pgru_pkg::pgru_item_t  item,
	input  logic [15:0]           image_count,
	input  logic [15:0]           tolerance,
	output logic                  clearing,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pgru_pkg::pgru_out_t   out_data
);
	import pgru_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_READ, S_LOAD, S_ADJ, S_DIV1, S_POST1, S_DIV2, S_POST2,
		S_FIN, S_DONE
	} state_t;
	typedef enum logic [1:0] {K_EST, K_NEG, K_POS} kind_t;

	logic signed [VAL_W-1:0] gain_mem [1<<IDX_W];
	logic signed [VAL_W-1:0] rdata_q;

	state_t                  state_q;
	kind_t                   kind_q;
	logic [IDX_W-1:0]        clr_idx_q;
	pgru_item_t              it_q;
	logic signed [VAL_W-1:0] g_q;
	logic                    neg_q;
	logic                    dev_neg_q;
	logic [3:0]              code_q;
	logic [SUM_W-1:0]        devabs_q;
	logic                    bad_en_q, unres_en_q;
	logic [CNT_W-1:0]        ovf_cnt_q, bad_cnt_q, unres_cnt_q;
	logic [SUM_W-1:0]        dev_sum_q;
	pgru_out_t               out_q;
	logic                    out_valid_q;

	logic                    div_start, div_short, div_done;
	logic [NUM_W-1:0]        div_num;
	logic [31:0]             div_den;
	logic [QUO_W-1:0]        div_quo;

	pgru_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.short_run (div_short),
		.num       (div_num),
		.den       (div_den),
		.done      (div_done),
		.quo       (div_quo)
	);

	logic [VAL_W-1:0]        gmag, vmag, tol32;
	logic signed [VAL_W-1:0] g_est;
	logic [32:0]             ng, mx;
	logic [33:0]             tsum;
	logic [31:0]             tsat;
	logic [34:0]             v15;
	logic [QUO_W:0]          rnd;
	logic [32:0]             m;
	logic                    m_big;
	logic [15:0]             low;
	logic signed [16:0]      devr;
	logic [15:0]             devr_mag;
	logic [QUO_W-1:0]        ovf_mag;
	logic [19:0]             den2;
	logic [15:0]             cnt_eff;
	logic signed [32:0]      gs;
	logic                    bad, out_free;
	logic signed [VAL_W-1:0] g_fin;

	always_comb begin
		tol32   = {16'd0, tolerance};
		gmag    = mag32(g_q);
		vmag    = mag32(it_q.value);
		g_est   = (mag32(rdata_q) < tol32 || rdata_q == '0) ? GAIN_MAX : rdata_q;
		ng      = 33'(-{g_q[VAL_W-1], g_q});
		mx      = ({1'b0, it_q.value} > ng) ? {1'b0, it_q.value} : ng;
		tsum    = {1'b0, mx} + {18'd0, tolerance};
		tsat    = (tsum > 34'h0_8000_0000) ? 32'h8000_0000 : tsum[31:0];
		v15     = {it_q.value[30:0], 4'd0} - {4'd0, it_q.value[30:0]};
		rnd     = {1'b0, div_quo} + (QUO_W+1)'(16'h8000);
		m       = rnd[QUO_W:16];
		m_big   = |m[32:4];
		low     = div_quo[15:0];
		devr    = div_quo[15] ? 17'sh1_0000 - $signed({1'b0, low}) : -$signed({1'b0, low});
		devr_mag = devr[16] ? 16'(-devr) : devr[15:0];
		ovf_mag = div_quo - QUO_W'(20'hF_0000);
		cnt_eff = (image_count == '0) ? 16'd1 : image_count;
		den2    = m[3:0] * cnt_eff;
		gs      = $signed({g_q[VAL_W-1], g_q}) +
			(dev_neg_q ? $signed({17'd0, div_quo[15:0]}) : -$signed({17'd0, div_quo[15:0]}));
		bad     = bad_en_q && (devabs_q > {32'd0, tolerance});
		g_fin   = (bad && !it_q.is_est && !g_q[VAL_W-1] && g_q != '0) ? -it_q.value : g_q;
		out_free = !out_valid_q || out_ready;
	end

	// Divider launch
	always_comb begin
		div_start = 1'b0;
		div_short = 1'b0;
		div_num   = {3'd0, vmag, 16'd0};
		div_den   = (gmag < vmag) ? gmag : vmag;
		if (state_q == S_ADJ) begin
			if (it_q.is_est) begin
				div_start = !it_q.v_zero;
			end else if (!it_q.v_nonpos) begin
				div_start = 1'b1;
				if (g_q[VAL_W-1] || g_q == '0) begin
					div_num = {v15, 16'd0};
					div_den = tsat;
				end else begin
					div_den = g_q;
				end
			end
		end else if (state_q == S_POST1) begin
			div_start = kind_q == K_POS && !m_big && m != '0;
			div_short = 1'b1;
			div_num   = {35'd0, devr_mag};
			div_den   = {12'd0, den2};
		end
	end

	assign clearing   = state_q == S_CLEAR;
	assign item_ready = state_q == S_IDLE;
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	// Gain table: clearing sweep after reset, one write per finished item
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) gain_mem[clr_idx_q] <= '0;
		else if (state_q == S_DONE && out_free) gain_mem[it_q.idx] <= g_q;
		rdata_q <= gain_mem[it_q.idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
			ovf_cnt_q   <= '0;
			bad_cnt_q   <= '0;
			unres_cnt_q <= '0;
			dev_sum_q   <= '0;
			kind_q      <= K_EST;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + IDX_W'(1);
					if (&clr_idx_q) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (item_valid) begin
						it_q    <= item;
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_LOAD;
				S_LOAD: begin
					if (it_q.pass_start) begin
						ovf_cnt_q   <= '0;
						bad_cnt_q   <= '0;
						unres_cnt_q <= '0;
						dev_sum_q   <= '0;
					end
					g_q        <= it_q.is_est ? g_est : rdata_q;
					code_q     <= '0;
					bad_en_q   <= 1'b0;
					unres_en_q <= 1'b0;
					devabs_q   <= '0;
					state_q    <= S_ADJ;
				end
				S_ADJ: begin
					if (it_q.is_est) begin
						kind_q <= K_EST;
						if (it_q.v_zero) begin
							state_q <= S_FIN;
						end else begin
							if (!(gmag < vmag)) g_q <= it_q.value;
							neg_q    <= it_q.value[VAL_W-1] ^
								((gmag < vmag) ? g_q[VAL_W-1] : it_q.value[VAL_W-1]);
							bad_en_q <= 1'b1;
							state_q  <= S_DIV1;
						end
					end else begin
						unres_en_q <= 1'b1;
						if (it_q.v_nonpos) begin
							state_q <= S_FIN;
						end else begin
							bad_en_q <= 1'b1;
							neg_q    <= 1'b0;
							state_q  <= S_DIV1;
							if (g_q[VAL_W-1] || g_q == '0) begin
								kind_q <= K_NEG;
								g_q    <= -$signed(tsat);
							end else begin
								kind_q <= K_POS;
							end
						end
					end
				end
				S_DIV1: if (div_done) state_q <= S_POST1;
				S_POST1: begin
					state_q <= S_FIN;
					case (kind_q)
						K_EST: begin
							if (neg_q) begin
								dev_sum_q <= add_sat(dev_sum_q, {32'd0, devr_mag});
								devabs_q  <= {32'd0, devr_mag};
							end else if (m_big) begin
								ovf_cnt_q <= inc_sat(ovf_cnt_q);
								code_q    <= 4'd15;
								dev_sum_q <= add_sat(dev_sum_q, ovf_mag);
								devabs_q  <= ovf_mag;
							end else begin
								code_q    <= m[3:0];
								dev_sum_q <= add_sat(dev_sum_q, {32'd0, devr_mag});
								devabs_q  <= {32'd0, devr_mag};
							end
						end
						K_NEG: begin
							code_q   <= m[3:0];
							devabs_q <= {32'd0, devr_mag};
						end
						default: begin
							devabs_q  <= {32'd0, devr_mag};
							dev_neg_q <= devr[16];
							if (m_big) begin
								ovf_cnt_q <= inc_sat(ovf_cnt_q);
								code_q    <= 4'd15;
								dev_sum_q <= add_sat(dev_sum_q, ovf_mag);
							end else begin
								code_q    <= m[3:0];
								dev_sum_q <= add_sat(dev_sum_q, {32'd0, devr_mag});
								if (m != '0) state_q <= S_DIV2;
							end
						end
					endcase
				end
				S_DIV2: if (div_done) state_q <= S_POST2;
				S_POST2: begin
					// Clamp only on top: the step is at most one half in magnitude
					g_q     <= (gs > 33'sh0_7FFF_FFFF) ? GAIN_MAX : gs[VAL_W-1:0];
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (bad) bad_cnt_q <= inc_sat(bad_cnt_q);
					if (unres_en_q && (g_fin[VAL_W-1] || g_fin == '0))
						unres_cnt_q <= inc_sat(unres_cnt_q);
					g_q     <= g_fin;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_q.out_index       <= it_q.idx;
			out_q.new_gain        <= g_q;
			out_q.code            <= code_q;
			out_q.overflows       <= ovf_cnt_q;
			out_q.bad_pixels      <= bad_cnt_q;
			out_q.unresolved      <= unres_cnt_q;
			out_q.deviation_total <= dev_sum_q;
		end
	end
endmodule

@@ hw/rtl/pixel_gain_reference_update_top.sv @@
// Top level of the pixel gain reference update block: configuration registers,
// front queue and back end. Depends on pgru_pkg, pgru_front and pgru_back.
//
// Each item is one pixel (index, signed Q16.16 value, pass start flag) and yields
// exactly one result: the updated gain, the rounded 4-bit code and the running
// statistics after that pixel. After reset the block sweeps the 16384-entry gain
// table to zero; input ready stays low during the sweep, configuration writes are
// taken at any time. The back end runs one full-width division for an
// item in estimate mode, and in refine mode when no refinement step is taken (a
// non-positive stored gain, a zero code or a code overflow); a refinement step
// adds a 16-bit division and a step to apply the result to the gain. Pixels
// that need no division (a zero value in estimate mode, a non-positive value in
// refine mode) skip the divider. The iterative divider yields two quotient bits
// a cycle over a 48-bit quotient and then hands the quotient over. A two-entry
// queue lets new pixels arrive while one is in work, and the result register
// holds a finished item while the next one proceeds.
module pixel_gain_reference_update_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pgru_pkg::pgru_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output pgru_pkg::pgru_out_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import pgru_pkg::*;

	logic             mode_q;
	logic [CFG_W-1:0] image_count_q;
	logic [CFG_W-1:0] tolerance_q;
	logic             clearing;
	logic             item_valid, item_ready;
	pgru_item_t       item;

	// Register writes always complete; unused indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= 1'b0;
			image_count_q <= 16'd1;
			tolerance_q   <= 16'd66;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE:        mode_q        <= cfg_data[0];
				REG_IMAGE_COUNT: image_count_q <= cfg_data;
				REG_TOLERANCE:   tolerance_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: accept and classify, hold items while the table sweep runs
	pgru_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.hold       (clearing),
		.mode       (mode_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	// Back: table update, statistics and the result register
	pgru_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.image_count (image_count_q),
		.tolerance   (tolerance_q),
		.clearing    (clearing),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);
endmodule
